/* src/ffha_pkg.sv */
// shared types and constants for the first-fit heap allocator
`default_nettype none
package ffha_pkg;

    localparam int FIELD_W = 12;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_RD_IDX,
        CMD_NEXT,
        CMD_FAIL,
        CMD_NULL,
        CMD_HIT,
        CMD_RD_J,
        CMD_WR_JUP,
        CMD_WR_JDN,
        CMD_WR_REM,
        CMD_WR_ALLOC,
        CMD_RD_NXT,
        CMD_MERGE_N,
        CMD_DEC,
        CMD_RD_PRV,
        CMD_MERGE_P,
        CMD_WR_CUR,
        CMD_PUBLISH
    } dp_cmd_t;

    typedef struct packed {
        logic match;
        logic idx_last;
        logic idx_zero;
        logic split_ok;
        logic rd_free;
        logic j_lt_cnt;
        logic j_at_lo;
        logic null_rel;
        logic is_release;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

/* src/ffha_dp.sv */
// datapath: block table memory, scan and shift registers, result register
`default_nettype none
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 12,
    parameter int MAX_BLOCKS   = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              stat,
    input  wire logic               operation,
    input  wire logic [FIELD_W-1:0] request_size,
    input  wire logic [FIELD_W-1:0] release_address,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [FIELD_W-1:0]      payload_address,
    output logic [1:0]              status
);

    localparam int SZ_W  = $clog2(HEAP_BYTES + 1);
    localparam int AW    = (SZ_W > FIELD_W) ? SZ_W : FIELD_W;
    localparam int MW    = AW + 1;
    localparam int EW    = 2 * SZ_W + 1;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [MW-1:0]    HDR  = MW'(HEADER_BYTES);
    localparam logic [SZ_W-1:0]  SIZE0 = SZ_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0] CMAX = CNT_W'(MAX_BLOCKS);

    logic [EW-1:0] mem [MAX_BLOCKS];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [EW-1:0]      cur_reg, cur_next;
    logic               split_reg, split_next;
    logic               op_reg, op_next;
    logic [FIELD_W-1:0] req_reg, req_next;
    logic [FIELD_W-1:0] addr_reg, addr_next;
    logic [FIELD_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [EW-1:0]      rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] payload_address_reg;
    logic [1:0]         status_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [EW-1:0]      wr_data;

    logic               rd_used;
    logic [MW-1:0]      rd_start, rd_size, cur_start, cur_size, req_w, addr_w;
    logic [CNT_W-1:0]   idx_c;
    logic [MW-1:0]      rem_start, rem_size, merge_n, merge_p, cur_pay;

    always_comb
    begin
        rd_used   = rd_data_reg[EW-1];
        rd_start  = MW'(rd_data_reg[2*SZ_W-1:SZ_W]);
        rd_size   = MW'(rd_data_reg[SZ_W-1:0]);
        cur_start = MW'(cur_reg[2*SZ_W-1:SZ_W]);
        cur_size  = MW'(cur_reg[SZ_W-1:0]);
        req_w     = MW'(req_reg);
        addr_w    = MW'(addr_reg);
        idx_c     = CNT_W'(idx_reg);
        rem_start = cur_start + HDR + req_w;
        rem_size  = cur_size - req_w - HDR;
        merge_n   = cur_size + HDR + rd_size;
        merge_p   = rd_size + HDR + cur_size;
        cur_pay   = cur_start + HDR;
    end

    always_comb
    begin
        stat.is_release = (op_reg == OP_RELEASE);
        stat.null_rel   = stat.is_release && (addr_reg == '0);
        stat.match      = stat.is_release ? (rd_used && (rd_start + HDR == addr_w))
                                          : (!rd_used && (rd_size >= req_w));
        stat.idx_last   = (idx_c + CNT_W'(1) == count_reg);
        stat.idx_zero   = (idx_reg == '0);
        stat.split_ok   = (rd_size > req_w + HDR) && (count_reg < CMAX);
        stat.rd_free    = !rd_used;
        stat.j_lt_cnt   = (j_reg < count_reg);
        stat.j_at_lo    = (j_reg == idx_c + CNT_W'(1));
        stat.out_busy   = out_valid_reg && out_stall;
    end

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        split_next      = split_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = cur_reg;
        case (cmd)
            CMD_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {1'b0, {SZ_W{1'b0}}, SIZE0};
                count_next = CNT_W'(1);
            end
            CMD_LOAD:
            begin
                op_next   = operation;
                req_next  = request_size;
                addr_next = release_address;
                idx_next  = '0;
            end
            CMD_RD_IDX:
            begin
                rd_en = 1'b1;
            end
            CMD_NEXT:
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
            CMD_FAIL:
            begin
                res_addr_next   = '0;
                res_status_next = stat.is_release ? ST_INVALID : ST_NO_FIT;
            end
            CMD_NULL:
            begin
                res_addr_next   = '0;
                res_status_next = ST_RELEASED;
            end
            CMD_HIT:
            begin
                cur_next   = {(stat.is_release ? 1'b0 : rd_used), rd_data_reg[EW-2:0]};
                split_next = stat.split_ok;
                j_next     = count_reg - CNT_W'(1);
            end
            CMD_RD_J:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg[IDX_W-1:0];
            end
            CMD_WR_JUP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0] + IDX_W'(1);
                wr_data = rd_data_reg;
                j_next  = j_reg - CNT_W'(1);
            end
            CMD_WR_JDN:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0] - IDX_W'(1);
                wr_data = rd_data_reg;
                j_next  = j_reg + CNT_W'(1);
            end
            CMD_WR_REM:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg + IDX_W'(1);
                wr_data    = {1'b0, rem_start[SZ_W-1:0], rem_size[SZ_W-1:0]};
                count_next = count_reg + CNT_W'(1);
            end
            CMD_WR_ALLOC:
            begin
                wr_en           = 1'b1;
                wr_data         = {1'b1, cur_reg[2*SZ_W-1:SZ_W],
                                   (split_reg ? req_w[SZ_W-1:0] : cur_reg[SZ_W-1:0])};
                res_addr_next   = cur_pay[FIELD_W-1:0];
                res_status_next = ST_ALLOCATED;
            end
            CMD_RD_NXT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + IDX_W'(1);
            end
            CMD_MERGE_N:
            begin
                cur_next = {cur_reg[EW-1:SZ_W], merge_n[SZ_W-1:0]};
                j_next   = idx_c + CNT_W'(2);
            end
            CMD_DEC:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            CMD_RD_PRV:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg - IDX_W'(1);
            end
            CMD_MERGE_P:
            begin
                cur_next = {1'b0, rd_data_reg[2*SZ_W-1:SZ_W], merge_p[SZ_W-1:0]};
                j_next   = idx_c + CNT_W'(1);
                idx_next = idx_reg - IDX_W'(1);
            end
            CMD_WR_CUR:
            begin
                wr_en           = 1'b1;
                res_addr_next   = '0;
                res_status_next = ST_RELEASED;
            end
            CMD_PUBLISH:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        cur_reg        <= cur_next;
        split_reg      <= split_next;
        op_reg         <= op_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (cmd == CMD_PUBLISH)
        begin
            payload_address_reg <= res_addr_reg;
            status_reg          <= res_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_address = payload_address_reg;
    assign status          = status_reg;

endmodule
`default_nettype wire

/* src/ffha_ctrl.sv */
// controller state machine sequencing scans, shifts, splits and merges
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t stat,
    output dp_cmd_t         cmd
);

    typedef enum logic [21:0] {
        S_INIT    = 22'b0000000000000000000001,
        S_IDLE    = 22'b0000000000000000000010,
        S_SRD     = 22'b0000000000000000000100,
        S_SCMP    = 22'b0000000000000000001000,
        S_SHU_RD  = 22'b0000000000000000010000,
        S_SHU_WR  = 22'b0000000000000000100000,
        S_SPLIT   = 22'b0000000000000001000000,
        S_ALLOC   = 22'b0000000000000010000000,
        S_RN_RD   = 22'b0000000000000100000000,
        S_RN_CMP  = 22'b0000000000001000000000,
        S_RM_CHK  = 22'b0000000000010000000000,
        S_RM_RD   = 22'b0000000000100000000000,
        S_RM_WR   = 22'b0000000001000000000000,
        S_RM_END  = 22'b0000000010000000000000,
        S_RP_CHK  = 22'b0000000100000000000000,
        S_RP_CMP  = 22'b0000001000000000000000,
        S_RM2_CHK = 22'b0000010000000000000000,
        S_RM2_RD  = 22'b0000100000000000000000,
        S_RM2_WR  = 22'b0001000000000000000000,
        S_RM2_END = 22'b0010000000000000000000,
        S_WR_CUR  = 22'b0100000000000000000000,
        S_FIN     = 22'b1000000000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_INIT:
            begin
                cmd        = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                if (stat.null_rel)
                begin
                    cmd        = CMD_NULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = CMD_RD_IDX;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (stat.match)
                begin
                    cmd = CMD_HIT;
                    if (stat.is_release)
                        state_next = stat.idx_last ? S_RP_CHK : S_RN_RD;
                    else if (!stat.split_ok)
                        state_next = S_ALLOC;
                    else
                        state_next = stat.idx_last ? S_SPLIT : S_SHU_RD;
                end
                else if (stat.idx_last)
                begin
                    cmd        = CMD_FAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = CMD_NEXT;
                    state_next = S_SRD;
                end
            end
            S_SHU_RD:
            begin
                cmd        = CMD_RD_J;
                state_next = S_SHU_WR;
            end
            S_SHU_WR:
            begin
                cmd        = CMD_WR_JUP;
                state_next = stat.j_at_lo ? S_SPLIT : S_SHU_RD;
            end
            S_SPLIT:
            begin
                cmd        = CMD_WR_REM;
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd        = CMD_WR_ALLOC;
                state_next = S_FIN;
            end
            S_RN_RD:
            begin
                cmd        = CMD_RD_NXT;
                state_next = S_RN_CMP;
            end
            S_RN_CMP:
            begin
                if (stat.rd_free)
                begin
                    cmd        = CMD_MERGE_N;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_RP_CHK;
                end
            end
            S_RM_CHK:
            begin
                state_next = stat.j_lt_cnt ? S_RM_RD : S_RM_END;
            end
            S_RM_RD:
            begin
                cmd        = CMD_RD_J;
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                cmd        = CMD_WR_JDN;
                state_next = S_RM_CHK;
            end
            S_RM_END:
            begin
                cmd        = CMD_DEC;
                state_next = S_RP_CHK;
            end
            S_RP_CHK:
            begin
                if (stat.idx_zero)
                begin
                    state_next = S_WR_CUR;
                end
                else
                begin
                    cmd        = CMD_RD_PRV;
                    state_next = S_RP_CMP;
                end
            end
            S_RP_CMP:
            begin
                if (stat.rd_free)
                begin
                    cmd        = CMD_MERGE_P;
                    state_next = S_RM2_CHK;
                end
                else
                begin
                    state_next = S_WR_CUR;
                end
            end
            S_RM2_CHK:
            begin
                state_next = stat.j_lt_cnt ? S_RM2_RD : S_RM2_END;
            end
            S_RM2_RD:
            begin
                cmd        = CMD_RD_J;
                state_next = S_RM2_WR;
            end
            S_RM2_WR:
            begin
                cmd        = CMD_WR_JDN;
                state_next = S_RM2_CHK;
            end
            S_RM2_END:
            begin
                cmd        = CMD_DEC;
                state_next = S_WR_CUR;
            end
            S_WR_CUR:
            begin
                cmd        = CMD_WR_CUR;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd        = CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* src/first_fit_heap_allocator.sv */
// top level of the first-fit heap allocator
//
// input channel: in_valid / in_stall carries operation, request_size and
// release_address; one transaction is one allocate or release request
// output channel: out_valid / out_stall carries payload_address and status,
// exactly one transaction per request, in request order
// requests are handled one at a time; the block table memory has one read
// and one write port, so the walk reads and then compares each block visited
// allocate: the scan stops at the first free block that fits; on a split the
// entries above it move up one slot before the remainder block is written
// release: the scan looks for the used block at release_address; a free next
// or previous block is merged in, moving the entries above it down one slot
// reset: the S_INIT state after reset loads the table with a single free block
// and then in_stall drops
// a finished result sits in the output register while the next request is
// taken; if out_stall holds it there, the next result waits before publishing
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 12,
    parameter int MAX_BLOCKS   = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               operation,
    input  wire logic [FIELD_W-1:0] request_size,
    input  wire logic [FIELD_W-1:0] release_address,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [FIELD_W-1:0]      payload_address,
    output logic [1:0]              status
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .request_size    (request_size),
        .release_address (release_address),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .payload_address (payload_address),
        .status          (status)
    );

endmodule
`default_nettype wire
